// ===== sv/baa_pkg.sv =====
// ============================================================================
// baa_pkg - shared constants and tanh table for the bias add + activation core
// Number formats, mode codes and the piecewise-linear tanh ROM built at
// elaboration from integer arithmetic.
// ============================================================================
`default_nettype none

package baa_pkg;

    // data format: signed Q5.10 in 16 bits
    localparam int DATA_W        = 16;
    localparam int FRAC_BITS     = 10;
    localparam int TANH_SEGMENTS = 64;
    localparam int SEG_BITS      = 6;   // log2 of TANH_SEGMENTS
    localparam int TANH_W        = 17;  // Q16 in [0, 1.0]
    localparam int NUM_STAGES    = 8;

    // activation modes
    localparam logic [1:0] MODE_GELU = 2'd0;
    localparam logic [1:0] MODE_TANH = 2'd1;
    localparam logic [1:0] MODE_RELU = 2'd2;
    localparam logic [1:0] MODE_PASS = 2'd3;

    // register index (paddr word index)
    localparam logic REG_ACT_MODE = 1'b0;

    // fixed-point constants, Q20
    localparam logic [15:0] C_CUBIC   = 16'd46887;   // 0.044715
    localparam logic [19:0] C_SQRT2PI = 20'd836643;  // sqrt(2/pi)

    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

    typedef logic [TANH_SEGMENTS:0][TANH_W-1:0] rom_t;

    // per-item control carried along the pipe
    typedef struct packed {
        logic [DATA_W-1:0] s;     // saturated sum
        logic [DATA_W-1:0] m;     // |sum|
        logic              neg;
        logic              sat;
        logic              last;
        logic [1:0]        mode;
    } ctl_t;

    // shift-subtract divide, elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], num[b]};
            if (r >= den) begin
                r    = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // entry k = round(tanh(4k/S) * 2^16); exp via Taylor in Q30, squared 4x
    function automatic rom_t build_tanh_rom();
        rom_t        rom;
        logic [63:0] z;
        logic [63:0] term;
        logic [63:0] e;
        logic [63:0] num;
        logic [63:0] den;
        rom = '0;
        for (int k = 0; k <= TANH_SEGMENTS; k++) begin
            z    = (64'(k) << 29) / TANH_SEGMENTS;
            term = ONE_Q30;
            e    = ONE_Q30;
            for (int n = 1; n <= 20; n++) begin
                term = udiv64((term * z) >> 30, 64'(n));
                if ((n % 2) == 1) begin
                    e = e - term;
                end else begin
                    e = e + term;
                end
            end
            for (int i = 0; i < 4; i++) begin
                e = (e * e) >> 30;
            end
            num    = (ONE_Q30 - e) << 16;
            den    = ONE_Q30 + e;
            rom[k] = TANH_W'(udiv64(num + (den >> 1), den));
        end
        return rom;
    endfunction

    localparam rom_t TANH_ROM = build_tanh_rom();

endpackage

`default_nettype wire

// ===== sv/bias_add_activation.sv =====
// ============================================================================
// bias_add_activation - streaming bias add with GELU / tanh / ReLU activation
// Saturating Q5.10 add of element and bias, then the selected activation
// built on a 64-segment piecewise-linear tanh ROM.
// ============================================================================
// Throughput: one transaction per cycle while the output is not stalled;
//   the eight-stage pipe advances per stage, so bubbles close up and a
//   stalled output only holds full stages.
// Reset: aresetn (synchronous, active low) clears all stage valid bits and
//   sets act_mode to GELU. The tanh ROM is constant; no clearing pass.
`default_nettype none

module bias_add_activation (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // input stream
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [31:0] s_tdata,   // [15:0] value, [31:16] bias
    input  wire logic        s_tlast,   // row_end

    // result stream
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [15:0] m_tdata,   // [15:0] result
    output      logic        m_tuser,   // [0] saturated
    output      logic        m_tlast,   // row_end_out

    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output      logic [31:0] prdata,
    output      logic        pready
);

    localparam int NS = baa_pkg::NUM_STAGES;
    localparam int DW = baa_pkg::DATA_W;

    // ------------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------------
    logic [1:0] act_mode_reg;
    logic [1:0] act_mode_next;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == baa_pkg::REG_ACT_MODE);

    always_comb begin
        act_mode_next = act_mode_reg;
        if (cfg_wr) begin
            act_mode_next = pwdata[1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_mode_reg <= baa_pkg::MODE_GELU;
        end else begin
            act_mode_reg <= act_mode_next;
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == baa_pkg::REG_ACT_MODE) begin
            prdata = {30'd0, act_mode_reg};
        end
    end

    // ------------------------------------------------------------------------
    // Pipeline flow control: a stage loads when it is empty or its
    // successor loads in the same cycle. The last stage is the output reg.
    // ------------------------------------------------------------------------
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] vld_next;
    logic [NS-1:0] stg_en;

    always_comb begin
        stg_en[NS-1] = !vld_reg[NS-1] || m_tready;
        for (int i = NS - 2; i >= 0; i--) begin
            stg_en[i] = !vld_reg[i] || stg_en[i+1];
        end
    end

    always_comb begin
        vld_next = vld_reg;
        if (stg_en[0]) begin
            vld_next[0] = s_tvalid;
        end
        for (int i = 1; i < NS; i++) begin
            if (stg_en[i]) begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = stg_en[0];
    assign m_tvalid = vld_reg[NS-1];

    // ------------------------------------------------------------------------
    // Stage 0: saturating add, magnitude and sign
    // ------------------------------------------------------------------------
    logic [DW:0]       sum_wide;
    logic [DW-1:0]     sum_sat;
    logic              sum_clip;
    baa_pkg::ctl_t     ctl_next;
    baa_pkg::ctl_t     ctl_reg [NS];

    always_comb begin
        sum_wide = {s_tdata[15], s_tdata[15:0]} + {s_tdata[31], s_tdata[31:16]};
        sum_clip = sum_wide[DW] != sum_wide[DW-1];
        if (sum_clip) begin
            // positive overflow -> max, negative -> min
            sum_sat = sum_wide[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        end else begin
            sum_sat = sum_wide[DW-1:0];
        end
        ctl_next.s    = sum_sat;
        ctl_next.neg  = sum_sat[DW-1];
        ctl_next.m    = sum_sat[DW-1] ? (~sum_sat + 1'b1) : sum_sat;  // -min = 0x8000
        ctl_next.sat  = sum_clip;
        ctl_next.last = s_tlast;
        ctl_next.mode = act_mode_reg;
    end

    // control fields ride along with each stage
    always_ff @(posedge aclk) begin
        if (stg_en[0]) begin
            ctl_reg[0] <= ctl_next;
        end
        for (int i = 1; i < NS; i++) begin
            if (stg_en[i]) begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stage 1: square of the low magnitude bits (|s| < 4.0 fits 12 bits)
    // ------------------------------------------------------------------------
    logic [11:0] m12_s1_reg, m12_s1_next;
    logic [23:0] sq_s1_reg,  sq_s1_next;
    logic        big_s1_reg, big_s1_next;

    always_comb begin
        m12_s1_next = ctl_reg[0].m[11:0];
        sq_s1_next  = m12_s1_next * m12_s1_next;
        big_s1_next = |ctl_reg[0].m[DW-1:12];
    end

    always_ff @(posedge aclk) begin
        if (stg_en[1]) begin
            m12_s1_reg <= m12_s1_next;
            sq_s1_reg  <= sq_s1_next;
            big_s1_reg <= big_s1_next;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 2: cube in Q16 = (m<<6)^3 >> 32 = m^3 >> 14
    // ------------------------------------------------------------------------
    logic [11:0] m12_s2_reg;
    logic [21:0] cube_s2_reg, cube_s2_next;
    logic        big_s2_reg;
    logic [35:0] cube_full;

    always_comb begin
        cube_full    = sq_s1_reg * m12_s1_reg;
        cube_s2_next = cube_full[35:14];
    end

    always_ff @(posedge aclk) begin
        if (stg_en[2]) begin
            m12_s2_reg  <= m12_s1_reg;
            cube_s2_reg <= cube_s2_next;
            big_s2_reg  <= big_s1_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 3: inner = x + 0.044715 x^3
    // ------------------------------------------------------------------------
    logic [17:0] mg_s3_reg,    mg_s3_next;
    logic [18:0] inner_s3_reg, inner_s3_next;
    logic        big_s3_reg;
    logic [37:0] cubic_term;

    always_comb begin
        mg_s3_next    = {m12_s2_reg, 6'd0};
        cubic_term    = cube_s2_reg * baa_pkg::C_CUBIC;
        inner_s3_next = {1'b0, mg_s3_next} + {1'b0, cubic_term[37:20]};
    end

    always_ff @(posedge aclk) begin
        if (stg_en[3]) begin
            mg_s3_reg    <= mg_s3_next;
            inner_s3_reg <= inner_s3_next;
            big_s3_reg   <= big_s2_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 4: tanh argument; sqrt(2/pi)*inner for GELU, |s| for tanh
    // ------------------------------------------------------------------------
    logic [18:0] arg_s4_reg, arg_s4_next;
    logic        big_s4_reg;
    logic [38:0] u_full;

    always_comb begin
        u_full = inner_s3_reg * baa_pkg::C_SQRT2PI;
        if (ctl_reg[3].mode == baa_pkg::MODE_GELU) begin
            arg_s4_next = u_full[38:20];
        end else begin
            arg_s4_next = {1'b0, mg_s3_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (stg_en[4]) begin
            arg_s4_reg <= arg_s4_next;
            big_s4_reg <= big_s3_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 5: ROM lookup of segment endpoints
    // ------------------------------------------------------------------------
    logic [baa_pkg::SEG_BITS-1:0] seg_idx;
    logic [baa_pkg::SEG_BITS:0]   seg_lo;
    logic [baa_pkg::SEG_BITS:0]   seg_hi;
    logic [baa_pkg::TANH_W-1:0]   y0_s5_reg, y0_s5_next;
    logic [baa_pkg::TANH_W-1:0]   dy_s5_reg, dy_s5_next;
    logic [11:0]                  frac_s5_reg;
    logic                         one_s5_reg, one_s5_next;

    always_comb begin
        seg_idx     = arg_s4_reg[17:12];
        seg_lo      = {1'b0, seg_idx};
        seg_hi      = seg_lo + 1'b1;
        y0_s5_next  = baa_pkg::TANH_ROM[seg_lo];
        dy_s5_next  = baa_pkg::TANH_ROM[seg_hi] - y0_s5_next;
        // |x| >= 4.0 either at the input or at the tanh argument -> tanh = 1
        one_s5_next = big_s4_reg || arg_s4_reg[18];
    end

    always_ff @(posedge aclk) begin
        if (stg_en[5]) begin
            y0_s5_reg   <= y0_s5_next;
            dy_s5_reg   <= dy_s5_next;
            frac_s5_reg <= arg_s4_reg[11:0];
            one_s5_reg  <= one_s5_next;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 6: linear interpolation, T in Q16
    // ------------------------------------------------------------------------
    logic [baa_pkg::TANH_W-1:0] t_s6_reg, t_s6_next;
    logic [28:0]                interp;

    always_comb begin
        interp = dy_s5_reg * frac_s5_reg;
        if (one_s5_reg) begin
            t_s6_next = baa_pkg::TANH_W'(1 << 16);
        end else begin
            t_s6_next = y0_s5_reg + interp[28:12];
        end
    end

    always_ff @(posedge aclk) begin
        if (stg_en[6]) begin
            t_s6_reg <= t_s6_next;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 7 (output register): final activation
    // GELU: +/-((|s| * (1 +/- T) + 0.5) >> 1) with T in Q16.
    // No result can leave the 16-bit range here, so only the sum clip flags.
    // ------------------------------------------------------------------------
    logic [DW-1:0] result_reg, result_next;
    logic [17:0]   gelu_fac;
    logic [33:0]   gelu_prod;
    logic [DW-1:0] gelu_mag;
    logic [16:0]   tanh_rnd;
    logic [DW-1:0] tanh_mag;

    always_comb begin
        if (ctl_reg[6].neg) begin
            gelu_fac = 18'h10000 - {1'b0, t_s6_reg};
        end else begin
            gelu_fac = 18'h10000 + {1'b0, t_s6_reg};
        end
        gelu_prod = ctl_reg[6].m * gelu_fac + 34'h10000;
        gelu_mag  = gelu_prod[32:17];
        tanh_rnd  = t_s6_reg + 17'd32;           // Q16 -> Q10, round half up
        tanh_mag  = {5'd0, tanh_rnd[16:6]};

        case (ctl_reg[6].mode)
            baa_pkg::MODE_GELU: begin
                result_next = ctl_reg[6].neg ? (~gelu_mag + 1'b1) : gelu_mag;
            end
            baa_pkg::MODE_TANH: begin
                result_next = ctl_reg[6].neg ? (~tanh_mag + 1'b1) : tanh_mag;
            end
            baa_pkg::MODE_RELU: begin
                result_next = ctl_reg[6].neg ? '0 : ctl_reg[6].s;
            end
            default: begin
                result_next = ctl_reg[6].s;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (stg_en[NS-1]) begin
            result_reg <= result_next;
        end
    end

    assign m_tdata = result_reg;
    assign m_tuser = ctl_reg[NS-1].sat;
    assign m_tlast = ctl_reg[NS-1].last;

endmodule

`default_nettype wire

// ===== sv/baa_checker.sv =====
// ============================================================================
// baa_checker - port-level checks for bias_add_activation
// Watches the stream and configuration ports over time.
// ============================================================================
`default_nettype none

module baa_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        m_tlast,
    input wire logic        pready
);

    // held result keeps its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result changed while stalled");

    // output stage is empty right after reset
    a_reset_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result valid right after reset");

    // an empty or draining output stage lets input in
    a_ready_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input stalled while output free");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready low");

endmodule

bind bias_add_activation baa_checker u_baa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .pready   (pready)
);

`default_nettype wire
